// ===== hw/rtl/sdr_pkg.sv =====
`timescale 1ns / 1ps

package sdr_pkg;

	// field widths
	localparam int IN_W  = 16;
	localparam int OUT_W = 16;

	// internal fixed point: unit vectors in q1.30
	localparam int FRAC      = 30;
	localparam int OUT_SHIFT = FRAC - (OUT_W - 2);

	// the largest aligned magnitude lies in [2^(AL_W-1), 2^AL_W), or is zero
	localparam int AL_W  = FRAC;
	// magnitude width ahead of alignment (projection remainder may reach 2^32)
	localparam int MAG_W = AL_W + 3;

	// alignment stages: negative is a right shift, positive a left shift
	localparam int ALN_ST              = 7;
	localparam int ALN_LAT             = ALN_ST + 1;
	localparam int ALN_SHIFT [ALN_ST]  = '{-2, -1, 16, 8, 4, 2, 1};

	// square root chain
	localparam int SQ_W       = 2 * AL_W + 2;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int REM_W      = ROOT_W + 4;
	localparam int SQRT_STEPS = ROOT_W;

	// division chain, one quotient bit per cell
	localparam int Q_W       = AL_W + 1;
	localparam int DIV_STEPS = Q_W;

	// normalize unit: squares, sum, root, divide
	localparam int UNIT_LAT = 2 + SQRT_STEPS + DIV_STEPS;

	// signed unit-vector component
	localparam int C_W = AL_W + 2;

	typedef logic [2:0][MAG_W-1:0] mvec_t;
	typedef logic [2:0][AL_W-1:0]  avec_t;
	typedef logic signed [C_W-1:0] cval_t;

	typedef struct packed {
		logic [SQ_W-1:0]   s;
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0]  rem;
	} sq_t;

	typedef struct packed {
		logic [ROOT_W-1:0] rem;
		logic [Q_W-1:0]    q;
		logic [Q_W-1:0]    lo;
	} dl_t;

	typedef struct packed {
		logic [ROOT_W-1:0] n;
		dl_t [2:0]         ln;
	} dv_t;

	// divide by 2^n, rounding half away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
			input int n);
		logic [63:0] m;
		if (n == 0) begin
			return v;
		end
		m = v[63] ? (~v + 64'd1) : v;
		m = (m + (64'd1 << (n - 1))) >> n;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

	// clamp to +-2^(OUT_W-2)
	function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] v);
		logic signed [63:0] lim;
		lim = 64'sd1 <<< (OUT_W - 2);
		if (v > lim) begin
			return OUT_W'(lim);
		end
		if (v < -lim) begin
			return OUT_W'(-lim);
		end
		return OUT_W'(v);
	endfunction

endpackage

// ===== hw/rtl/six_d_rotation_to_matrix_top.sv =====
`timescale 1ns / 1ps
// channel   valid      stall      payload
// request   vec_valid  vec_stall  a_x b_x a_y b_y a_z b_z  (q4.12)
// result    mat_valid  mat_stall  m00..m22 (q1.14), degenerate
//
// one request per cycle unless a held result is stalled; each result passes
// through the two normalize units (31 root cells and 31 divide cells each)
// plus two alignment shifters, projection, cross product and the output register
// arst_n clears only the valid line; the datapath needs no reset
// a stalled result freezes the whole pipeline, so vec_stall follows mat_stall
// while a result is held
module six_d_rotation_to_matrix_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vec_valid,
	output logic                              vec_stall,
	input  logic signed [sdr_pkg::IN_W-1:0]   a_x,
	input  logic signed [sdr_pkg::IN_W-1:0]   b_x,
	input  logic signed [sdr_pkg::IN_W-1:0]   a_y,
	input  logic signed [sdr_pkg::IN_W-1:0]   b_y,
	input  logic signed [sdr_pkg::IN_W-1:0]   a_z,
	input  logic signed [sdr_pkg::IN_W-1:0]   b_z,
	output logic                              mat_valid,
	input  logic                              mat_stall,
	output logic signed [sdr_pkg::OUT_W-1:0]  m00,
	output logic signed [sdr_pkg::OUT_W-1:0]  m01,
	output logic signed [sdr_pkg::OUT_W-1:0]  m02,
	output logic signed [sdr_pkg::OUT_W-1:0]  m10,
	output logic signed [sdr_pkg::OUT_W-1:0]  m11,
	output logic signed [sdr_pkg::OUT_W-1:0]  m12,
	output logic signed [sdr_pkg::OUT_W-1:0]  m20,
	output logic signed [sdr_pkg::OUT_W-1:0]  m21,
	output logic signed [sdr_pkg::OUT_W-1:0]  m22,
	output logic                              degenerate
);
	import sdr_pkg::*;

	localparam int PRJ_LAT = 5;
	localparam int C1_DLY  = PRJ_LAT + ALN_LAT + UNIT_LAT;
	localparam int TOT_LAT = 2 * ALN_LAT + 2 * UNIT_LAT + PRJ_LAT + 3;
	localparam int DW      = C_W + 2;   // rounded dot product
	localparam int RW      = DW + 1;    // remainder of b

	// global advance: everything moves unless the held result is stalled
	logic adv;
	assign adv       = !(mat_valid && mat_stall);
	assign vec_stall = !adv;

	logic [TOT_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOT_LAT-2:0], vec_valid};
		end
	end

	assign mat_valid = vld_q[TOT_LAT-1];

	function automatic logic [MAG_W-1:0] mag_in(input logic signed [IN_W-1:0] v);
		logic [IN_W-1:0] t;
		t = v[IN_W-1] ? (~v + 1'b1) : v;
		return MAG_W'(t);
	endfunction

	// split into magnitude and sign
	mvec_t a_mag;
	mvec_t b_mag;

	always_comb begin
		a_mag[0] = mag_in(a_x);
		a_mag[1] = mag_in(a_y);
		a_mag[2] = mag_in(a_z);
		b_mag[0] = mag_in(b_x);
		b_mag[1] = mag_in(b_y);
		b_mag[2] = mag_in(b_z);
	end

	avec_t      aa_mag;
	avec_t      ba_mag;
	logic [2:0] aa_sgn;
	logic [2:0] ba_sgn;
	logic       aa_zero;
	logic       ba_zero;

	// both vectors scaled up so the largest component sits just under 2^30
	sdr_align u_aln_a (
		.clk(clk), .en(adv), .mag(a_mag),
		.sgn({a_z[IN_W-1], a_y[IN_W-1], a_x[IN_W-1]}),
		.amag(aa_mag), .asgn(aa_sgn), .zero(aa_zero)
	);

	sdr_align u_aln_b (
		.clk(clk), .en(adv), .mag(b_mag),
		.sgn({b_z[IN_W-1], b_y[IN_W-1], b_x[IN_W-1]}),
		.amag(ba_mag), .asgn(ba_sgn), .zero(ba_zero)
	);

	// c1 = a / |a|
	cval_t c1 [3];
	logic  a_zero;

	sdr_unit u_unit_a (
		.clk(clk), .en(adv), .mag(aa_mag), .sgn(aa_sgn), .zero_in(aa_zero),
		.c(c1), .zero_out(a_zero)
	);

	// aligned b waits beside the first normalize unit; zero b needs no flag
	// of its own since its remainder is zero as well
	avec_t      bd_q [UNIT_LAT];
	logic [2:0] bsg_q [UNIT_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			bd_q[0]  <= ba_mag;
			bsg_q[0] <= ba_sgn;
			for (int k = 1; k < UNIT_LAT; k++) begin
				bd_q[k]  <= bd_q[k-1];
				bsg_q[k] <= bsg_q[k-1];
			end
		end
	end

	logic signed [AL_W:0] bs [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bs[i] = bsg_q[UNIT_LAT-1][i] ? -$signed({1'b0, bd_q[UNIT_LAT-1][i]})
				: $signed({1'b0, bd_q[UNIT_LAT-1][i]});
		end
	end

	// projection: r = b - round(round(c1.b) * c1)
	logic signed [C_W+AL_W:0] pr_s1 [3];
	cval_t                    c1_s1 [3];
	cval_t                    c1_s2 [3];
	cval_t                    c1_s3 [3];
	logic signed [AL_W:0]     bs_s1 [3];
	logic signed [AL_W:0]     bs_s2 [3];
	logic signed [AL_W:0]     bs_s3 [3];
	logic signed [AL_W:0]     bs_s4 [3];
	logic signed [63:0]       dot_s2;
	logic signed [DW-1:0]     d_s3;
	logic signed [63:0]       pd_s4 [3];
	logic signed [RW-1:0]     rv [3];
	mvec_t                    r_mag_s5;
	logic [2:0]               r_sgn_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rv[i] = RW'(bs_s4[i]) - RW'(rnd_shift(pd_s4[i], FRAC));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pr_s1[i] <= c1[i] * bs[i];
				pd_s4[i] <= d_s3 * c1_s3[i];
				r_mag_s5[i] <= rv[i][RW-1] ? MAG_W'(-rv[i]) : MAG_W'(rv[i]);
				r_sgn_s5[i] <= rv[i][RW-1];
			end
			c1_s1  <= c1;
			c1_s2  <= c1_s1;
			c1_s3  <= c1_s2;
			bs_s1  <= bs;
			bs_s2  <= bs_s1;
			bs_s3  <= bs_s2;
			bs_s4  <= bs_s3;
			dot_s2 <= 64'(pr_s1[0]) + 64'(pr_s1[1]) + 64'(pr_s1[2]);
			d_s3   <= DW'(rnd_shift(dot_s2, FRAC));
		end
	end

	// remainder realigned (may shrink right or grow left) then normalized
	avec_t      ra_mag;
	logic [2:0] ra_sgn;
	logic       ra_zero;

	sdr_align u_aln_r (
		.clk(clk), .en(adv), .mag(r_mag_s5), .sgn(r_sgn_s5),
		.amag(ra_mag), .asgn(ra_sgn), .zero(ra_zero)
	);

	cval_t c2 [3];
	logic  r_zero;

	sdr_unit u_unit_r (
		.clk(clk), .en(adv), .mag(ra_mag), .sgn(ra_sgn), .zero_in(ra_zero),
		.c(c2), .zero_out(r_zero)
	);

	// c1 and its zero flag wait for c2
	cval_t c1d_q [C1_DLY][3];
	logic  azd_q [C1_DLY];

	always_ff @(posedge clk) begin
		if (adv) begin
			c1d_q[0] <= c1;
			azd_q[0] <= a_zero;
			for (int k = 1; k < C1_DLY; k++) begin
				c1d_q[k] <= c1d_q[k-1];
				azd_q[k] <= azd_q[k-1];
			end
		end
	end

	// c3 = c1 x c2, exact in q2.60
	logic signed [63:0] xp_s1 [6];
	logic signed [63:0] c3_s2 [3];
	cval_t              c1x_s1 [3];
	cval_t              c1x_s2 [3];
	cval_t              c2x_s1 [3];
	cval_t              c2x_s2 [3];
	logic               dg_s1;
	logic               dg_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s1[0] <= c1d_q[C1_DLY-1][1] * c2[2];
			xp_s1[1] <= c1d_q[C1_DLY-1][2] * c2[1];
			xp_s1[2] <= c1d_q[C1_DLY-1][2] * c2[0];
			xp_s1[3] <= c1d_q[C1_DLY-1][0] * c2[2];
			xp_s1[4] <= c1d_q[C1_DLY-1][0] * c2[1];
			xp_s1[5] <= c1d_q[C1_DLY-1][1] * c2[0];
			c1x_s1   <= c1d_q[C1_DLY-1];
			c2x_s1   <= c2;
			dg_s1    <= azd_q[C1_DLY-1] | r_zero;
			c3_s2[0] <= xp_s1[0] - xp_s1[1];
			c3_s2[1] <= xp_s1[2] - xp_s1[3];
			c3_s2[2] <= xp_s1[4] - xp_s1[5];
			c1x_s2   <= c1x_s1;
			c2x_s2   <= c2x_s1;
			dg_s2    <= dg_s1;
		end
	end

	// output register: round to q1.14 and clamp
	logic [OUT_W-1:0] mo_q [3][3];
	logic             deg_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				mo_q[i][0] <= sat_out(rnd_shift(64'(c1x_s2[i]), OUT_SHIFT));
				mo_q[i][1] <= sat_out(rnd_shift(64'(c2x_s2[i]), OUT_SHIFT));
				mo_q[i][2] <= sat_out(rnd_shift(c3_s2[i], FRAC + OUT_SHIFT));
			end
			deg_q <= dg_s2;
		end
	end

	assign m00        = $signed(mo_q[0][0]);
	assign m01        = $signed(mo_q[0][1]);
	assign m02        = $signed(mo_q[0][2]);
	assign m10        = $signed(mo_q[1][0]);
	assign m11        = $signed(mo_q[1][1]);
	assign m12        = $signed(mo_q[1][2]);
	assign m20        = $signed(mo_q[2][0]);
	assign m21        = $signed(mo_q[2][1]);
	assign m22        = $signed(mo_q[2][2]);
	assign degenerate = deg_q;

endmodule

// ===== hw/rtl/sdr_align.sv =====
`timescale 1ns / 1ps

module sdr_align (
	input  logic             clk,
	input  logic             en,
	input  sdr_pkg::mvec_t   mag,
	input  logic [2:0]       sgn,
	output sdr_pkg::avec_t   amag,
	output logic [2:0]       asgn,
	output logic             zero
);
	import sdr_pkg::*;

	mvec_t            mg_q [ALN_LAT];
	logic [MAG_W-1:0] mx_q [ALN_LAT];
	logic [2:0]       sg_q [ALN_LAT];
	logic             zr_q [ALN_LAT];
	logic [MAG_W-1:0] mx_in;

	function automatic logic do_shift(input logic [MAG_W-1:0] mx, input int sh);
		if (sh < 0) begin
			return mx >= (MAG_W'(1) << (AL_W - 1 - sh));
		end
		return mx < (MAG_W'(1) << (AL_W - sh));
	endfunction

	function automatic logic [MAG_W-1:0] shift_one(input logic [MAG_W-1:0] v,
			input int sh);
		if (sh < 0) begin
			return v >> (-sh);
		end
		return v << sh;
	endfunction

	always_comb begin
		mx_in = mag[0];
		if (mag[1] > mx_in) begin
			mx_in = mag[1];
		end
		if (mag[2] > mx_in) begin
			mx_in = mag[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mg_q[0] <= mag;
			mx_q[0] <= mx_in;
			sg_q[0] <= sgn;
			zr_q[0] <= (mx_in == '0);
			for (int k = 0; k < ALN_ST; k++) begin
				for (int i = 0; i < 3; i++) begin
					mg_q[k+1][i] <= do_shift(mx_q[k], ALN_SHIFT[k]) ?
						shift_one(mg_q[k][i], ALN_SHIFT[k]) : mg_q[k][i];
				end
				mx_q[k+1] <= do_shift(mx_q[k], ALN_SHIFT[k]) ?
					shift_one(mx_q[k], ALN_SHIFT[k]) : mx_q[k];
				sg_q[k+1] <= sg_q[k];
				zr_q[k+1] <= zr_q[k];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amag[i] = mg_q[ALN_ST][i][AL_W-1:0];
		end
	end

	assign asgn = sg_q[ALN_ST];
	assign zero = zr_q[ALN_ST];

endmodule

// ===== hw/rtl/sdr_sqrt_cell.sv =====
`timescale 1ns / 1ps

module sdr_sqrt_cell (
	input  logic         clk,
	input  logic         en,
	input  sdr_pkg::sq_t din,
	output sdr_pkg::sq_t dout
);
	import sdr_pkg::*;

	logic [REM_W-1:0] r2;
	logic [REM_W-1:0] trial;
	logic             ge;

	// bring in the next two radicand bits, try root*4+1
	assign r2    = {din.rem[REM_W-3:0], din.s[SQ_W-1 -: 2]};
	assign trial = REM_W'({din.root, 2'b01});
	assign ge    = (r2 >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			dout.s    <= {din.s[SQ_W-3:0], 2'b00};
			dout.root <= {din.root[ROOT_W-2:0], ge};
			dout.rem  <= ge ? (r2 - trial) : r2;
		end
	end

endmodule

// ===== hw/rtl/sdr_div_cell.sv =====
`timescale 1ns / 1ps

module sdr_div_cell (
	input  logic         clk,
	input  logic         en,
	input  sdr_pkg::dv_t din,
	output sdr_pkg::dv_t dout
);
	import sdr_pkg::*;

	logic [ROOT_W:0] r2 [3];
	logic [2:0]      ge;

	// restoring step, three lanes share one divisor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r2[i] = {din.ln[i].rem, din.ln[i].lo[Q_W-1]};
			ge[i] = (r2[i] >= {1'b0, din.n});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.n <= din.n;
			for (int i = 0; i < 3; i++) begin
				dout.ln[i].rem <= ge[i] ? ROOT_W'(r2[i] - {1'b0, din.n}) : ROOT_W'(r2[i]);
				dout.ln[i].q   <= {din.ln[i].q[Q_W-2:0], ge[i]};
				dout.ln[i].lo  <= {din.ln[i].lo[Q_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== hw/rtl/sdr_unit.sv =====
`timescale 1ns / 1ps

module sdr_unit (
	input  logic           clk,
	input  logic           en,
	input  sdr_pkg::avec_t mag,
	input  logic [2:0]     sgn,
	input  logic           zero_in,
	output sdr_pkg::cval_t c [3],
	output logic           zero_out
);
	import sdr_pkg::*;

	localparam int MGD = SQRT_STEPS + 2;

	logic [2*AL_W-1:0] sq_s1 [3];
	logic [SQ_W-1:0]   s_s2;
	avec_t             mgd_q [MGD];
	logic [2:0]        sg_q [UNIT_LAT];
	logic              zr_q [UNIT_LAT];
	sq_t               sq0;
	sq_t               sc [SQRT_STEPS];
	dv_t               dv0;
	dv_t               dv [DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= mag[i] * mag[i];
			end
			s_s2 <= SQ_W'(sq_s1[0]) + SQ_W'(sq_s1[1]) + SQ_W'(sq_s1[2]);
			mgd_q[0] <= mag;
			for (int k = 1; k < MGD; k++) begin
				mgd_q[k] <= mgd_q[k-1];
			end
			sg_q[0] <= sgn;
			zr_q[0] <= zero_in;
			for (int k = 1; k < UNIT_LAT; k++) begin
				sg_q[k] <= sg_q[k-1];
				zr_q[k] <= zr_q[k-1];
			end
		end
	end

	always_comb begin
		sq0.s    = s_s2;
		sq0.root = '0;
		sq0.rem  = '0;
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		if (k == 0) begin : g_first
			sdr_sqrt_cell u_cell (.clk(clk), .en(en), .din(sq0), .dout(sc[k]));
		end else begin : g_next
			sdr_sqrt_cell u_cell (.clk(clk), .en(en), .din(sc[k-1]), .dout(sc[k]));
		end
	end

	// numerator is mag*2^30 + n/2: high part mag/2, low bits {mag[0], n/2}
	always_comb begin
		dv0.n = sc[SQRT_STEPS-1].root;
		for (int i = 0; i < 3; i++) begin
			dv0.ln[i].rem = ROOT_W'(mgd_q[MGD-1][i] >> 1);
			dv0.ln[i].q   = '0;
			dv0.ln[i].lo  = {mgd_q[MGD-1][i][0], sc[SQRT_STEPS-1].root[ROOT_W-1:1]};
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		if (k == 0) begin : g_first
			sdr_div_cell u_cell (.clk(clk), .en(en), .din(dv0), .dout(dv[k]));
		end else begin : g_next
			sdr_div_cell u_cell (.clk(clk), .en(en), .din(dv[k-1]), .dout(dv[k]));
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (zr_q[UNIT_LAT-1]) begin
				c[i] = '0;
			end else if (sg_q[UNIT_LAT-1][i]) begin
				c[i] = -$signed(C_W'(dv[DIV_STEPS-1].ln[i].q));
			end else begin
				c[i] = $signed(C_W'(dv[DIV_STEPS-1].ln[i].q));
			end
		end
	end

	assign zero_out = zr_q[UNIT_LAT-1];

endmodule

// ===== bench/six_d_rotation_to_matrix_top_test.sv =====
`timescale 1ns / 1ps

module six_d_rotation_to_matrix_top_test;

	import sdr_pkg::*;

	// unit vectors are held in q1.30, results in q1.(OUT_W-2)
	localparam int UNIT_FRAC = 30;
	localparam int OUT_DROP  = UNIT_FRAC - (OUT_W - 2);
	localparam longint UNIT_ONE = 64'sd1 <<< UNIT_FRAC;
	localparam int PIPE_CYCLES = 152;

	typedef longint trip_t [3];

	// one joint: two interleaved 3-vectors
	typedef struct {
		logic signed [IN_W-1:0] ax, bx, ay, by, az, bz;
	} joint_t;

	// one rotation matrix, row-major m00..m22
	typedef struct {
		logic signed [OUT_W-1:0] m [9];
		logic                    degen;
	} rot_t;

	logic clk;
	logic arst_n;
	logic vec_valid;
	logic vec_stall;
	logic signed [IN_W-1:0] a_x, b_x, a_y, b_y, a_z, b_z;
	logic mat_valid;
	logic mat_stall;
	logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic degenerate;

	joint_t joints_pending [$];
	rot_t   mat_expected [$];
	int     fail_count = 0;
	bit     stim_done = 0;

	// append to the tail of the pending and expected queues
	task automatic add_joint(input joint_t j);
		joints_pending.insert(joints_pending.size(), j);
	endtask

	task automatic add_expected(input rot_t r);
		mat_expected.insert(mat_expected.size(), r);
	endtask

	six_d_rotation_to_matrix_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_stall(vec_stall),
		.a_x(a_x), .b_x(b_x), .a_y(a_y), .b_y(b_y), .a_z(a_z), .b_z(b_z),
		.mat_valid(mat_valid), .mat_stall(mat_stall),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22), .degenerate(degenerate)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// fixed-point gram-schmidt predictor
	// ---------------------------------------------------------------

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// divide by 2^n, rounding half away from zero
	function automatic longint round_down(longint v, int n);
		longint unsigned m;
		if (n == 0) begin
			return v;
		end
		m = (magnitude(v) + (64'd1 << (n - 1))) >> n;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	// bit-serial floor square root
	function automatic longint unsigned floor_sqrt(longint unsigned s);
		longint unsigned root;
		longint unsigned bt;
		root = 0;
		bt = 64'd1 << 62;
		while (bt > s) begin
			bt = bt >> 2;
		end
		while (bt != 0) begin
			if (s >= root + bt) begin
				s = s - (root + bt);
				root = (root >> 1) + bt;
			end else begin
				root = root >> 1;
			end
			bt = bt >> 2;
		end
		return root;
	endfunction

	// scale by a common power of two so the largest magnitude is in [2^29, 2^30)
	// magnitudes truncate on the way down; returns 0 for a zero vector
	function automatic bit align_vec(inout trip_t v);
		longint unsigned m [3];
		longint unsigned peak;
		peak = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = magnitude(v[i]);
			if (m[i] > peak) begin
				peak = m[i];
			end
		end
		if (peak == 0) begin
			return 1'b0;
		end
		while (peak >= UNIT_ONE) begin
			peak = peak >> 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
		end
		while (peak < (UNIT_ONE >> 1)) begin
			peak = peak << 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
		end
		for (int i = 0; i < 3; i++) begin
			v[i] = (v[i] < 0) ? -longint'(m[i]) : longint'(m[i]);
		end
		return 1'b1;
	endfunction

	// aligned nonzero vector to unit length in q1.30, quotient rounded
	function automatic trip_t normalize(trip_t v);
		trip_t c;
		longint unsigned sum_sq;
		longint unsigned len;
		longint unsigned q;
		sum_sq = 0;
		for (int i = 0; i < 3; i++) begin
			sum_sq = sum_sq + magnitude(v[i]) * magnitude(v[i]);
		end
		len = floor_sqrt(sum_sq);
		for (int i = 0; i < 3; i++) begin
			q = ((magnitude(v[i]) << UNIT_FRAC) + (len >> 1)) / len;
			c[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
		end
		return c;
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
		longint lim;
		lim = 64'sd1 <<< (OUT_W - 2);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v[OUT_W-1:0];
	endfunction

	function automatic rot_t gram_schmidt_predict(joint_t j);
		rot_t r;
		trip_t a, b, c1, c2, c3;
		longint dot;
		longint d;
		a = '{longint'(j.ax), longint'(j.ay), longint'(j.az)};
		b = '{longint'(j.bx), longint'(j.by), longint'(j.bz)};
		c1 = '{0, 0, 0};
		c2 = '{0, 0, 0};
		r.degen = 1'b0;
		if (align_vec(a)) begin
			c1 = normalize(a);
		end else begin
			r.degen = 1'b1;
		end
		if (align_vec(b)) begin
			// strip the projection on c1, then normalize what is left
			dot = 0;
			for (int i = 0; i < 3; i++) dot = dot + c1[i] * b[i];
			d = round_down(dot, UNIT_FRAC);
			for (int i = 0; i < 3; i++) b[i] = b[i] - round_down(d * c1[i], UNIT_FRAC);
			if (align_vec(b)) begin
				c2 = normalize(b);
			end else begin
				r.degen = 1'b1;
			end
		end else begin
			r.degen = 1'b1;
		end
		c3[0] = c1[1] * c2[2] - c1[2] * c2[1];
		c3[1] = c1[2] * c2[0] - c1[0] * c2[2];
		c3[2] = c1[0] * c2[1] - c1[1] * c2[0];
		for (int i = 0; i < 3; i++) begin
			r.m[3*i + 0] = clamp_out(round_down(c1[i], OUT_DROP));
			r.m[3*i + 1] = clamp_out(round_down(c2[i], OUT_DROP));
			r.m[3*i + 2] = clamp_out(round_down(c3[i], UNIT_FRAC + OUT_DROP));
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus generation
	// ---------------------------------------------------------------

	function automatic joint_t make_joint(longint ax, ay, az, bx, by, bz);
		joint_t j;
		j.ax = ax[IN_W-1:0]; j.ay = ay[IN_W-1:0]; j.az = az[IN_W-1:0];
		j.bx = bx[IN_W-1:0]; j.by = by[IN_W-1:0]; j.bz = bz[IN_W-1:0];
		return j;
	endfunction

	// full-range value, one shrunk by a random shift so small lengths show up, or zero
	function automatic logic signed [IN_W-1:0] rand_comp();
		logic signed [IN_W-1:0] v;
		v = IN_W'($urandom);
		if ($urandom_range(0, 2) == 0) begin
			v = v >>> $urandom_range(0, IN_W - 1);
		end
		if ($urandom_range(0, 9) == 0) begin
			v = '0;
		end
		return v;
	endfunction

	initial begin
		joint_t j;
		longint lo, hi;
		lo = -(64'sd1 <<< (IN_W - 1));
		hi = (64'sd1 <<< (IN_W - 1)) - 1;

		// directed: zero vectors, parallel cases, field extremes
		add_joint(make_joint(0, 0, 0, 0, 0, 0));
		add_joint(make_joint(0, 0, 0, 4096, 0, 0));
		add_joint(make_joint(0, 0, 0, lo, hi, lo));
		add_joint(make_joint(4096, 0, 0, 0, 0, 0));
		add_joint(make_joint(4096, 0, 0, 0, 4096, 0));
		add_joint(make_joint(0, 4096, 0, 0, 0, -4096));
		add_joint(make_joint(4096, 4096, 0, 8192, 8192, 0));
		add_joint(make_joint(300, -200, 100, -300, 200, -100));
		add_joint(make_joint(lo, lo, lo, hi, hi, hi));
		add_joint(make_joint(lo, lo, lo, lo, lo, lo));
		add_joint(make_joint(hi, hi, hi, hi, hi, lo));
		add_joint(make_joint(lo, 0, 0, 0, lo, 0));
		add_joint(make_joint(hi, 0, 0, 1, 1, 0));
		add_joint(make_joint(1, 0, 0, 0, 0, 1));
		add_joint(make_joint(1, 1, 1, -1, 1, -1));
		add_joint(make_joint(-1, -1, -1, lo, hi, 0));
		add_joint(make_joint(1, 2, 3, 2, 4, 6));
		add_joint(make_joint(hi, -1, 1, hi, 1, -1));
		add_joint(make_joint(0, 0, lo, hi, hi, hi));
		add_joint(make_joint(hi, lo, 1, lo, hi, -1));

		// random: mostly general joints, some with b parallel or antiparallel to a
		for (int n = 0; n < 1650; n++) begin
			j.ax = rand_comp(); j.ay = rand_comp(); j.az = rand_comp();
			case ($urandom_range(0, 9))
				0: begin
					j.bx = j.ax; j.by = j.ay; j.bz = j.az;
				end
				1: begin
					j.bx = -j.ax; j.by = -j.ay; j.bz = -j.az;
				end
				2: begin
					j.bx = j.ax >>> 1; j.by = j.ay >>> 1; j.bz = j.az >>> 1;
				end
				default: begin
					j.bx = rand_comp(); j.by = rand_comp(); j.bz = rand_comp();
				end
			endcase
			add_joint(j);
		end
		stim_done = 1'b1;
	end

	// ---------------------------------------------------------------
	// reset
	// ---------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------
	// request driver
	// ---------------------------------------------------------------

	int  req_gap = 0;
	bit  req_burst = 0;
	initial begin
		vec_valid = 1'b0;
		a_x = '0; b_x = '0; a_y = '0; b_y = '0; a_z = '0; b_z = '0;
	end

	always @(posedge clk) begin
		joint_t j;
		logic next_valid;
		if (arst_n) begin
			// a request taken at this edge gets its expected matrix now
			if (vec_valid && !vec_stall) begin
				j.ax = a_x; j.bx = b_x; j.ay = a_y; j.by = b_y; j.az = a_z; j.bz = b_z;
				add_expected(gram_schmidt_predict(j));
			end
			next_valid = vec_valid && vec_stall;
			if (!next_valid) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (joints_pending.size() > 0) begin
					j = joints_pending.pop_front();
					a_x <= j.ax; b_x <= j.bx; a_y <= j.ay;
					b_y <= j.by; a_z <= j.az; b_z <= j.bz;
					next_valid = 1'b1;
					// switch now and then between back-to-back bursts and gaps
					if ($urandom_range(0, 63) == 0) req_burst = ~req_burst;
					req_gap = req_burst ? 0 : $urandom_range(0, 11);
				end
			end
			vec_valid <= next_valid;
		end
	end

	// ---------------------------------------------------------------
	// result monitor
	// ---------------------------------------------------------------

	int  res_hold = 0;
	bit  res_burst = 0;
	initial mat_stall = 1'b0;

	always @(posedge clk) begin
		rot_t want;
		logic signed [OUT_W-1:0] got [9];
		if (arst_n) begin
			if (mat_valid && !mat_stall) begin
				got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
				if (mat_expected.size() == 0) begin
					$error("matrix arrived with no request outstanding");
					fail_count++;
				end else begin
					want = mat_expected.pop_front();
					for (int k = 0; k < 9; k++) begin
						if (got[k] !== want.m[k]) begin
							$error("m%0d%0d expected %0d actual %0d", k / 3, k % 3,
								want.m[k], got[k]);
							fail_count++;
						end
					end
					if (degenerate !== want.degen) begin
						$error("degenerate expected %0d actual %0d", want.degen, degenerate);
						fail_count++;
					end
				end
				if ($urandom_range(0, 63) == 0) res_burst = ~res_burst;
				res_hold = res_burst ? 0 : $urandom_range(0, 11);
			end else if (res_hold > 0) begin
				res_hold--;
			end
			mat_stall <= (res_hold > 0);
		end
	end

	// ---------------------------------------------------------------
	// end of run
	// ---------------------------------------------------------------

	initial begin
		@(posedge arst_n);
		while (!stim_done || joints_pending.size() > 0 || vec_valid
				|| mat_expected.size() > 0) begin
			@(posedge clk);
		end
		// let any stray matrix show up
		repeat (PIPE_CYCLES + 50) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sdr_pkg.sv
hw/rtl/sdr_align.sv
hw/rtl/sdr_sqrt_cell.sv
hw/rtl/sdr_div_cell.sv
hw/rtl/sdr_unit.sv
hw/rtl/six_d_rotation_to_matrix_top.sv
bench/six_d_rotation_to_matrix_top_test.sv
